### rtl/cubic_path_segment_coefficients_defines.svh
// Assertion macros shared by the cubic path segment coefficient RTL.
// No dependencies; included by the files that carry assertions.
`ifndef CUBIC_PATH_SEGMENT_COEFFICIENTS_DEFINES_SVH
`define CUBIC_PATH_SEGMENT_COEFFICIENTS_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define CPSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpsc: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define CPSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpsc: next-cycle check failed");

`else

`define CPSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CPSC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/cpsc_pkg.sv
// Package for the cubic path segment coefficient block: widths, types, register map.
// No dependencies.
package cpsc_pkg;

    localparam int MAX_POINTS = 128;
    localparam int N_STAGES   = 5;

    localparam int W_IDX  = 7;
    localparam int W_PT   = 28;
    localparam int W_LEN  = 8;
    localparam int W_DIFF = W_PT + 1;
    localparam int W_AB   = W_PT + 4;
    localparam int W_K2   = 2 * W_IDX;
    localparam int W_K3   = 3 * W_IDX;
    localparam int W_COEF = 64;

    localparam int W_PAK  = W_AB + W_IDX + 1;
    localparam int W_PAK2 = W_AB + W_K2 + 1;
    localparam int W_PAK3 = W_AB + W_K3 + 1;
    localparam int W_PCK  = W_DIFF + W_IDX + 1;

    localparam int W_APB  = 32;
    localparam int W_ADDR = 3;

    localparam logic [W_ADDR-3:0] IDX_PATH_LENGTH   = '0;
    localparam logic [W_LEN-1:0]  RESET_PATH_LENGTH = W_LEN'(2);

    typedef logic        [W_IDX-1:0]  t_idx;
    typedef logic signed [W_PT-1:0]   t_point;
    typedef logic signed [W_COEF-1:0] t_coef;

    typedef struct packed {
        logic [W_LEN-1:0] path_length;
    } t_cfg;

endpackage

### rtl/cpsc_if.sv
// Valid/ready channel interfaces for segment requests and coefficient results.
// Depends on cpsc_pkg.
interface cpsc_seg_if;
    logic             valid;
    logic             ready;
    cpsc_pkg::t_idx   segment_index;
    cpsc_pkg::t_point point_before;
    cpsc_pkg::t_point point_start;
    cpsc_pkg::t_point point_end;
    cpsc_pkg::t_point point_after;

    modport source (output valid, segment_index, point_before, point_start, point_end,
                    point_after, input ready);
    modport sink   (input valid, segment_index, point_before, point_start, point_end,
                    point_after, output ready);
endinterface

interface cpsc_coef_if;
    logic            valid;
    logic            ready;
    cpsc_pkg::t_coef coef_cubic;
    cpsc_pkg::t_coef coef_square;
    cpsc_pkg::t_coef coef_linear;
    cpsc_pkg::t_coef coef_constant;

    modport source (output valid, coef_cubic, coef_square, coef_linear, coef_constant,
                    input ready);
    modport sink   (input valid, coef_cubic, coef_square, coef_linear, coef_constant,
                    output ready);
endinterface

### rtl/cubic_path_segment_coefficients.sv
// Top level of the cubic path segment coefficient block: five-stage datapath.
// Depends on cpsc_pkg, cpsc_if, cpsc_apb_regs and the shared assertion macros.
//
// Usage:
//   i_seg carries one transaction per segment and axis: the segment index k and
//   the four neighboring control points in signed Q20.8. o_coef returns the four
//   coefficients A, B, C, D of p(t) = A t^3 + B t^2 + C t + D in global t,
//   signed Q56.8, 64 bits each, one result transaction per input transaction, in order.
//   The APB port holds path_length (byte address 0), which picks the last segment
//   for the one-sided end slope; writes above the maximum point count are clamped.
//   Write it only while the pipeline is empty.
// Timing:
//   Five register stages. A new transaction is accepted every cycle while o_coef.ready
//   is high or a stage is free; the six parallel multipliers of stage three set the
//   critical path. Stages: slopes, Hermite coefficients and k^3, products, partial
//   sums, final sums in the output register.
// Reset and stall:
//   Reset empties the pipeline and sets path_length to 2. When the receiver holds
//   o_coef.ready low, the last stage holds its result; earlier stages keep
//   advancing into empty slots, so i_seg.ready stays high while any slot is free.
`include "cubic_path_segment_coefficients_defines.svh"

module cubic_path_segment_coefficients (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cpsc_seg_if.sink                    i_seg,
    cpsc_coef_if.source                 o_coef,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpsc_pkg::W_ADDR-1:0] paddr,
    input  logic [cpsc_pkg::W_APB-1:0]  pwdata,
    output logic [cpsc_pkg::W_APB-1:0]  prdata,
    output logic                        pready
);

    cpsc_pkg::t_cfg w_cfg;

    cpsc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ------------------------------------------------------------------
    // Flow control: one valid bit per stage, ready ripples back from the
    // output so bubbles collapse under a stalled receiver.
    // ------------------------------------------------------------------
    logic [cpsc_pkg::N_STAGES-1:0] r_vld;
    logic [cpsc_pkg::N_STAGES-1:0] n_vld;
    logic [cpsc_pkg::N_STAGES-1:0] w_rdy;

    always_comb begin
        w_rdy[cpsc_pkg::N_STAGES-1] = !r_vld[cpsc_pkg::N_STAGES-1] || o_coef.ready;
        for (int i = cpsc_pkg::N_STAGES - 2; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_rdy[0]) begin
            n_vld[0] = i_seg.valid;
        end
        for (int i = 1; i < cpsc_pkg::N_STAGES; i++) begin
            if (w_rdy[i]) begin
                n_vld[i] = r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_seg.ready = w_rdy[0];

    // ------------------------------------------------------------------
    // Stage 1: end slopes, point difference, k^2.
    // Start slope is one-sided on the first segment, end slope on the last.
    // ------------------------------------------------------------------
    logic                               w_last;
    logic signed [cpsc_pkg::W_DIFF-1:0] n_s1_dp;
    logic signed [cpsc_pkg::W_DIFF-1:0] n_s1_m0;
    logic signed [cpsc_pkg::W_DIFF-1:0] n_s1_m1;
    logic        [cpsc_pkg::W_K2-1:0]   n_s1_k2;

    logic        [cpsc_pkg::W_IDX-1:0]  r_s1_k;
    logic        [cpsc_pkg::W_K2-1:0]   r_s1_k2;
    logic signed [cpsc_pkg::W_DIFF-1:0] r_s1_dp;
    logic signed [cpsc_pkg::W_DIFF-1:0] r_s1_m0;
    logic signed [cpsc_pkg::W_DIFF-1:0] r_s1_m1;
    logic signed [cpsc_pkg::W_PT-1:0]   r_s1_p0;

    always_comb begin
        w_last = (w_cfg.path_length != '0) &&
                 ((cpsc_pkg::W_LEN'(i_seg.segment_index) + cpsc_pkg::W_LEN'(1)) ==
                  (w_cfg.path_length - cpsc_pkg::W_LEN'(1)));

        n_s1_dp = cpsc_pkg::W_DIFF'(i_seg.point_end) - cpsc_pkg::W_DIFF'(i_seg.point_start);

        if (i_seg.segment_index == '0) begin
            n_s1_m0 = n_s1_dp;
        end else begin
            n_s1_m0 = cpsc_pkg::W_DIFF'(i_seg.point_end) -
                      cpsc_pkg::W_DIFF'(i_seg.point_before);
        end

        if (w_last) begin
            n_s1_m1 = n_s1_dp;
        end else begin
            n_s1_m1 = cpsc_pkg::W_DIFF'(i_seg.point_after) -
                      cpsc_pkg::W_DIFF'(i_seg.point_start);
        end

        n_s1_k2 = cpsc_pkg::W_K2'(i_seg.segment_index) * cpsc_pkg::W_K2'(i_seg.segment_index);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1_k  <= i_seg.segment_index;
            r_s1_k2 <= n_s1_k2;
            r_s1_dp <= n_s1_dp;
            r_s1_m0 <= n_s1_m0;
            r_s1_m1 <= n_s1_m1;
            r_s1_p0 <= i_seg.point_start;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: local Hermite coefficients in u = t - k, and k^3.
    //   a = m0 + m1 - 2 dp,  b = 3 dp - 2 m0 - m1,  c = m0,  d = p0
    // ------------------------------------------------------------------
    logic signed [cpsc_pkg::W_AB-1:0]   n_s2_a;
    logic signed [cpsc_pkg::W_AB-1:0]   n_s2_b;
    logic        [cpsc_pkg::W_K3-1:0]   n_s2_k3;

    logic signed [cpsc_pkg::W_AB-1:0]   r_s2_a;
    logic signed [cpsc_pkg::W_AB-1:0]   r_s2_b;
    logic signed [cpsc_pkg::W_DIFF-1:0] r_s2_c;
    logic signed [cpsc_pkg::W_PT-1:0]   r_s2_d;
    logic        [cpsc_pkg::W_IDX-1:0]  r_s2_k;
    logic        [cpsc_pkg::W_K2-1:0]   r_s2_k2;
    logic        [cpsc_pkg::W_K3-1:0]   r_s2_k3;

    always_comb begin
        n_s2_a  = cpsc_pkg::W_AB'(r_s1_m0) + cpsc_pkg::W_AB'(r_s1_m1) -
                  (cpsc_pkg::W_AB'(r_s1_dp) <<< 1);
        n_s2_b  = (cpsc_pkg::W_AB'(r_s1_dp) <<< 1) + cpsc_pkg::W_AB'(r_s1_dp) -
                  (cpsc_pkg::W_AB'(r_s1_m0) <<< 1) - cpsc_pkg::W_AB'(r_s1_m1);
        n_s2_k3 = cpsc_pkg::W_K3'(r_s1_k2) * cpsc_pkg::W_K3'(r_s1_k);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s2_a  <= n_s2_a;
            r_s2_b  <= n_s2_b;
            r_s2_c  <= r_s1_m0;
            r_s2_d  <= r_s1_p0;
            r_s2_k  <= r_s1_k;
            r_s2_k2 <= r_s1_k2;
            r_s2_k3 <= n_s2_k3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: products of the local coefficients with powers of k.
    // ------------------------------------------------------------------
    logic signed [cpsc_pkg::W_IDX:0]    w_k_s;
    logic signed [cpsc_pkg::W_K2:0]     w_k2_s;
    logic signed [cpsc_pkg::W_K3:0]     w_k3_s;

    logic signed [cpsc_pkg::W_PAK-1:0]  r_s3_ak;
    logic signed [cpsc_pkg::W_PAK2-1:0] r_s3_ak2;
    logic signed [cpsc_pkg::W_PAK3-1:0] r_s3_ak3;
    logic signed [cpsc_pkg::W_PAK-1:0]  r_s3_bk;
    logic signed [cpsc_pkg::W_PAK2-1:0] r_s3_bk2;
    logic signed [cpsc_pkg::W_PCK-1:0]  r_s3_ck;
    logic signed [cpsc_pkg::W_AB-1:0]   r_s3_a;
    logic signed [cpsc_pkg::W_AB-1:0]   r_s3_b;
    logic signed [cpsc_pkg::W_DIFF-1:0] r_s3_c;
    logic signed [cpsc_pkg::W_PT-1:0]   r_s3_d;

    assign w_k_s  = $signed({1'b0, r_s2_k});
    assign w_k2_s = $signed({1'b0, r_s2_k2});
    assign w_k3_s = $signed({1'b0, r_s2_k3});

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s3_ak  <= cpsc_pkg::W_PAK'(r_s2_a)  * cpsc_pkg::W_PAK'(w_k_s);
            r_s3_ak2 <= cpsc_pkg::W_PAK2'(r_s2_a) * cpsc_pkg::W_PAK2'(w_k2_s);
            r_s3_ak3 <= cpsc_pkg::W_PAK3'(r_s2_a) * cpsc_pkg::W_PAK3'(w_k3_s);
            r_s3_bk  <= cpsc_pkg::W_PAK'(r_s2_b)  * cpsc_pkg::W_PAK'(w_k_s);
            r_s3_bk2 <= cpsc_pkg::W_PAK2'(r_s2_b) * cpsc_pkg::W_PAK2'(w_k2_s);
            r_s3_ck  <= cpsc_pkg::W_PCK'(r_s2_c)  * cpsc_pkg::W_PCK'(w_k_s);
            r_s3_a   <= r_s2_a;
            r_s3_b   <= r_s2_b;
            r_s3_c   <= r_s2_c;
            r_s3_d   <= r_s2_d;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: partial sums of the expansion around k.
    //   t1 = 3ak, t2 = c - 2bk, t3 = 3ak^2, t4 = d - ck, t5 = bk^2 - ak^3
    // ------------------------------------------------------------------
    cpsc_pkg::t_coef                  n_s4_t1;
    cpsc_pkg::t_coef                  n_s4_t2;
    cpsc_pkg::t_coef                  n_s4_t3;
    cpsc_pkg::t_coef                  n_s4_t4;
    cpsc_pkg::t_coef                  n_s4_t5;

    cpsc_pkg::t_coef                  r_s4_t1;
    cpsc_pkg::t_coef                  r_s4_t2;
    cpsc_pkg::t_coef                  r_s4_t3;
    cpsc_pkg::t_coef                  r_s4_t4;
    cpsc_pkg::t_coef                  r_s4_t5;
    logic signed [cpsc_pkg::W_AB-1:0] r_s4_a;
    logic signed [cpsc_pkg::W_AB-1:0] r_s4_b;

    always_comb begin
        n_s4_t1 = cpsc_pkg::W_COEF'(r_s3_ak) + (cpsc_pkg::W_COEF'(r_s3_ak) <<< 1);
        n_s4_t2 = cpsc_pkg::W_COEF'(r_s3_c) - (cpsc_pkg::W_COEF'(r_s3_bk) <<< 1);
        n_s4_t3 = cpsc_pkg::W_COEF'(r_s3_ak2) + (cpsc_pkg::W_COEF'(r_s3_ak2) <<< 1);
        n_s4_t4 = cpsc_pkg::W_COEF'(r_s3_d) - cpsc_pkg::W_COEF'(r_s3_ck);
        n_s4_t5 = cpsc_pkg::W_COEF'(r_s3_bk2) - cpsc_pkg::W_COEF'(r_s3_ak3);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s4_t1 <= n_s4_t1;
            r_s4_t2 <= n_s4_t2;
            r_s4_t3 <= n_s4_t3;
            r_s4_t4 <= n_s4_t4;
            r_s4_t5 <= n_s4_t5;
            r_s4_a  <= r_s3_a;
            r_s4_b  <= r_s3_b;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: final sums into the output register; hold while stalled.
    // ------------------------------------------------------------------
    cpsc_pkg::t_coef r_s5_cubic;
    cpsc_pkg::t_coef r_s5_square;
    cpsc_pkg::t_coef r_s5_linear;
    cpsc_pkg::t_coef r_s5_constant;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_s5_cubic    <= cpsc_pkg::W_COEF'(r_s4_a);
            r_s5_square   <= cpsc_pkg::W_COEF'(r_s4_b) - r_s4_t1;
            r_s5_linear   <= r_s4_t2 + r_s4_t3;
            r_s5_constant <= r_s4_t4 + r_s4_t5;
        end
    end

    assign o_coef.valid         = r_vld[cpsc_pkg::N_STAGES-1];
    assign o_coef.coef_cubic    = r_s5_cubic;
    assign o_coef.coef_square   = r_s5_square;
    assign o_coef.coef_linear   = r_s5_linear;
    assign o_coef.coef_constant = r_s5_constant;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CPSC_ASSERT_IMP(a_free_slot_ready, i_clk, i_rst_n, (r_vld != '1), i_seg.ready)
    `CPSC_ASSERT_NXT(a_stage2_advance, i_clk, i_rst_n, (r_vld[1] && w_rdy[2]), r_vld[2])
    `CPSC_ASSERT_NXT(a_stage4_hold, i_clk, i_rst_n, (r_vld[3] && !w_rdy[3]), (r_vld[3] && $stable(r_s4_t1) && $stable(r_s4_t5)))
    `CPSC_ASSERT_IMP(a_len_clamped, i_clk, i_rst_n, 1'b1, (w_cfg.path_length <= cpsc_pkg::W_LEN'(cpsc_pkg::MAX_POINTS)))

endmodule

### rtl/cpsc_apb_regs.sv
// APB-style configuration register file holding the path length.
// Depends on cpsc_pkg.
module cpsc_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpsc_pkg::W_ADDR-1:0]   paddr,
    input  logic [cpsc_pkg::W_APB-1:0]    pwdata,
    output logic [cpsc_pkg::W_APB-1:0]    prdata,
    output logic                          pready,
    output cpsc_pkg::t_cfg                o_cfg
);

    logic [cpsc_pkg::W_LEN-1:0] r_path_length;
    logic [cpsc_pkg::W_LEN-1:0] n_path_length;
    logic                       w_sel_len;
    logic                       w_wr_len;

    assign pready    = 1'b1;
    assign w_sel_len = (paddr[cpsc_pkg::W_ADDR-1:2] == cpsc_pkg::IDX_PATH_LENGTH);
    assign w_wr_len  = psel && penable && pwrite && pready && w_sel_len;

    // Clamp oversize writes to the largest supported path.
    always_comb begin
        if (pwdata[cpsc_pkg::W_LEN-1:0] > cpsc_pkg::W_LEN'(cpsc_pkg::MAX_POINTS)) begin
            n_path_length = cpsc_pkg::W_LEN'(cpsc_pkg::MAX_POINTS);
        end else begin
            n_path_length = pwdata[cpsc_pkg::W_LEN-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_length <= cpsc_pkg::RESET_PATH_LENGTH;
        end else if (w_wr_len) begin
            r_path_length <= n_path_length;
        end
    end

    assign prdata            = w_sel_len ? cpsc_pkg::W_APB'(r_path_length) : '0;
    assign o_cfg.path_length = r_path_length;

endmodule
